// ----- rtl/app4d_pkg.sv -----
// Shared types, codes and constants of the APP4 auxiliary stream demultiplexer.
// Used by the parser, the result serialiser and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package app4d_pkg;

	// JPEG marker bytes.
	localparam logic [7:0] MARK_PREFIX = 8'hFF;
	localparam logic [7:0] MARK_APP4   = 8'hE4;
	localparam logic [7:0] MARK_SOS    = 8'hDA;

	// Four-character codes of the auxiliary formats, as read little-endian.
	localparam logic [31:0] FCC_H264 = 32'h34363248;
	localparam logic [31:0] FCC_YUY2 = 32'h32595559;
	localparam logic [31:0] FCC_NV12 = 32'h3231564E;

	// Bytes in the unit header, the unit size included.
	localparam logic [4:0] HDR_BYTES = 5'd26;
	// Byte offset of the unit size inside the header.
	localparam logic [4:0] SIZE_OFFSET = 5'd22;
	// The segment length counts its own two bytes.
	localparam logic [15:0] LEN_MIN = 16'd2;

	// Stream codes.
	localparam logic [1:0] STREAM_JPEG = 2'd0;
	localparam logic [1:0] STREAM_H264 = 2'd1;
	localparam logic [1:0] STREAM_YUY2 = 2'd2;
	localparam logic [1:0] STREAM_NV12 = 2'd3;

	typedef enum logic [1:0] {
		KIND_JPEG = 2'd0,
		KIND_AUX  = 2'd1,
		KIND_INFO = 2'd2,
		KIND_END  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_LEN_TRUNC   = 4'd1,
		ST_SEG_PAST    = 4'd2,
		ST_HDR_SHORT   = 4'd3,
		ST_UNKNOWN_FMT = 4'd4,
		ST_OVERSIZE    = 4'd5,
		ST_INCOMPLETE  = 4'd6,
		ST_NO_SOS      = 4'd7,
		ST_BAD_LENGTH  = 4'd8
	} status_t;

	// One result without the header values.
	typedef struct packed {
		kind_t      kind;
		logic [1:0] stream;
		logic [7:0] data;
		logic       unit_last;
		status_t    status;
	} slot_t;

	// Header values of a new unit; at most one such result per request.
	typedef struct packed {
		logic [15:0] width;
		logic [15:0] height;
		logic [31:0] frame_period;
		logic [15:0] delay;
		logic [31:0] pts;
		logic        format_changed;
	} info_t;

	// All results caused by one input request.
	typedef struct packed {
		logic [1:0]      count;
		slot_t [2:0]     slots;
		info_t           info;
	} bundle_t;

	function automatic slot_t mk_slot(kind_t k, logic [1:0] s, logic [7:0] d, logic ul,
		status_t st);
		slot_t r;
		r.kind      = k;
		r.stream    = s;
		r.data      = d;
		r.unit_last = ul;
		r.status    = st;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/app4d_in_if.sv -----
// Input channel of the APP4 demultiplexer: one frame byte per request.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface app4d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_last;

	modport source (output valid, output data_byte, output frame_last, input ready);
	modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/app4d_out_if.sv -----
// Result channel of the APP4 demultiplexer: one result per request.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface app4d_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  stream;
	logic [7:0]  out_byte;
	logic        unit_last;
	logic [15:0] width;
	logic [15:0] height;
	logic [31:0] frame_period;
	logic [15:0] delay;
	logic [31:0] pts;
	logic        format_changed;
	logic [3:0]  status;
	logic        run_last;

	modport source (output valid, output kind, output stream, output out_byte,
		output unit_last, output width, output height, output frame_period,
		output delay, output pts, output format_changed, output status,
		output run_last, input ready);
	modport sink (input valid, input kind, input stream, input out_byte,
		input unit_last, input width, input height, input frame_period,
		input delay, input pts, input format_changed, input status,
		input run_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/app4d_parser.sv -----
// Byte parser of the APP4 demultiplexer: marker search, segment and header
// decoding, and the results of each byte. Depends on app4d_pkg and app4d_in_if.
`timescale 1ns / 1ps
`default_nettype none

module app4d_parser
	import app4d_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	app4d_in_if.sink   frame,
	input  wire logic  bundle_ready,
	output logic       bundle_valid,
	output bundle_t    bundle
);

	typedef enum logic [2:0] {
		PH_SCAN,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_HEADER,
		PH_PAYLOAD,
		PH_PASS,
		PH_DISCARD
	} phase_t;

	phase_t       phase_q, phase_d;
	logic         held_q, held_d;
	logic [15:0]  seg_q, seg_d;
	logic [4:0]   cnt_q, cnt_d;
	logic [31:0]  aux_q, aux_d;
	logic         open_q, open_d;
	logic [63:0]  shift_q, shift_d;
	logic [47:0]  tail_q, tail_d;
	logic [31:0]  type_q, type_d;
	logic [1:0]   route_q, route_d;
	logic         sos_q, sos_d;
	status_t      err_q, err_d;
	logic [2:0][31:0] known_q, known_d;

	logic         fail_d;
	status_t      code_d;
	logic [1:0]   n_d;
	bundle_t      bundle_d;
	logic         ul_d;
	status_t      end_st;

	logic         accept;
	logic [7:0]   b;
	logic         fl;
	logic [15:0]  len_w;
	logic [15:0]  body_w;
	logic [4:0]   koff;
	logic [1:0]   route_w;
	logic [1:0]   ridx;
	logic [31:0]  ks_w;

	assign b      = frame.data_byte;
	assign fl     = frame.frame_last;
	assign accept = frame.valid && bundle_ready;
	assign frame.ready = bundle_ready;

	// Segment length and body, taken when the low length byte arrives.
	assign len_w  = {seg_q[15:8], b};
	assign body_w = len_w - LEN_MIN;
	assign koff   = cnt_q - SIZE_OFFSET;
	assign ks_w   = shift_q[31:0];
	assign ridx   = route_w - 2'd1;

	// Stream selected by the format code of the header.
	always_comb begin
		if (type_q == FCC_H264) begin
			route_w = STREAM_H264;
		end else if (type_q == FCC_YUY2) begin
			route_w = STREAM_YUY2;
		end else if (type_q == FCC_NV12) begin
			route_w = STREAM_NV12;
		end else begin
			route_w = STREAM_JPEG;
		end
	end

	// Next state and the results of the byte on the input.
	always_comb begin
		phase_d  = phase_q;
		held_d   = held_q;
		seg_d    = seg_q;
		cnt_d    = cnt_q;
		aux_d    = aux_q;
		open_d   = open_q;
		shift_d  = shift_q;
		tail_d   = tail_q;
		type_d   = type_q;
		route_d  = route_q;
		sos_d    = sos_q;
		err_d    = err_q;
		known_d  = known_q;
		fail_d   = 1'b0;
		code_d   = ST_OK;
		n_d      = 2'd0;
		bundle_d = '0;
		ul_d     = 1'b0;
		end_st   = ST_OK;

		case (phase_q)
			PH_LEN_HI: begin
				seg_d   = {b, 8'h00};
				phase_d = PH_LEN_LO;
				if (fl) begin
					fail_d = 1'b1;
					code_d = ST_LEN_TRUNC;
				end
			end
			PH_LEN_LO: begin
				if (fl) begin
					fail_d = 1'b1;
					code_d = ST_LEN_TRUNC;
				end else if (len_w < LEN_MIN) begin
					fail_d = 1'b1;
					code_d = ST_BAD_LENGTH;
				end else if (!open_q) begin
					// A new unit: the segment must hold the whole header.
					if (body_w < {11'd0, HDR_BYTES}) begin
						fail_d = 1'b1;
						code_d = ST_HDR_SHORT;
					end else begin
						seg_d   = body_w;
						cnt_d   = 5'd0;
						shift_d = '0;
						tail_d  = '0;
						type_d  = '0;
						aux_d   = '0;
						phase_d = PH_HEADER;
					end
				end else begin
					// Continuation of an open unit.
					if ({16'd0, body_w} > aux_q) begin
						fail_d = 1'b1;
						code_d = ST_OVERSIZE;
					end else begin
						seg_d   = body_w;
						phase_d = (body_w != 16'd0) ? PH_PAYLOAD : PH_SCAN;
					end
				end
			end
			PH_HEADER: begin
				if (fl) begin
					fail_d = 1'b1;
					code_d = ST_SEG_PAST;
				end else begin
					seg_d = seg_q - 16'd1;
					cnt_d = cnt_q + 5'd1;
					// Store the header byte in its field.
					if (cnt_q >= 5'd4 && cnt_q < 5'd8) begin
						type_d[{cnt_q[1:0], 3'b000} +: 8] = b;
					end else if (cnt_q >= 5'd8 && cnt_q < 5'd16) begin
						shift_d[{cnt_q[2:0], 3'b000} +: 8] = b;
					end else if (cnt_q >= 5'd16 && cnt_q < 5'd22) begin
						tail_d[{cnt_q[2:0], 3'b000} +: 8] = b;
					end else if (cnt_q >= SIZE_OFFSET && cnt_q < HDR_BYTES) begin
						aux_d[{koff[1:0], 3'b000} +: 8] = b;
					end
					// Header complete: report it and open the unit if its size is non-zero.
					if (cnt_d == HDR_BYTES) begin
						if (aux_d != 32'd0 && route_w == STREAM_JPEG) begin
							fail_d = 1'b1;
							code_d = ST_UNKNOWN_FMT;
						end else begin
							if (aux_d != 32'd0) begin
								bundle_d.slots[n_d] = mk_slot(KIND_INFO, route_w, 8'h00,
									1'b0, ST_OK);
								n_d = n_d + 2'd1;
								bundle_d.info.width          = ks_w[15:0];
								bundle_d.info.height         = ks_w[31:16];
								bundle_d.info.frame_period   = shift_q[63:32];
								bundle_d.info.delay          = tail_q[15:0];
								bundle_d.info.pts            = tail_q[47:16];
								bundle_d.info.format_changed = (known_q[ridx] != ks_w);
								known_d[ridx] = ks_w;
								open_d  = 1'b1;
								route_d = route_w;
							end
							if ({16'd0, seg_d} > aux_d) begin
								fail_d = 1'b1;
								code_d = ST_OVERSIZE;
							end else begin
								phase_d = (seg_d != 16'd0) ? PH_PAYLOAD : PH_SCAN;
							end
						end
					end
				end
			end
			PH_PAYLOAD: begin
				if (fl) begin
					fail_d = 1'b1;
					code_d = ST_SEG_PAST;
				end else begin
					aux_d = aux_q - 32'd1;
					seg_d = seg_q - 16'd1;
					if (aux_d == 32'd0) begin
						ul_d   = 1'b1;
						open_d = 1'b0;
					end
					bundle_d.slots[n_d] = mk_slot(KIND_AUX, route_q, b, ul_d, ST_OK);
					n_d = n_d + 2'd1;
					if (seg_d == 16'd0) begin
						phase_d = PH_SCAN;
					end
				end
			end
			PH_PASS: begin
				bundle_d.slots[n_d] = mk_slot(KIND_JPEG, STREAM_JPEG, b, 1'b0, ST_OK);
				n_d = n_d + 2'd1;
			end
			PH_DISCARD: begin
				phase_d = PH_DISCARD;
			end
			default: begin
				// Marker search.
				phase_d = PH_SCAN;
				if (held_q) begin
					if (b == MARK_APP4) begin
						held_d  = 1'b0;
						phase_d = PH_LEN_HI;
						if (fl) begin
							fail_d = 1'b1;
							code_d = ST_LEN_TRUNC;
						end
					end else if (b == MARK_PREFIX) begin
						bundle_d.slots[n_d] = mk_slot(KIND_JPEG, STREAM_JPEG, MARK_PREFIX,
							1'b0, ST_OK);
						n_d = n_d + 2'd1;
					end else begin
						held_d = 1'b0;
						bundle_d.slots[n_d] = mk_slot(KIND_JPEG, STREAM_JPEG, MARK_PREFIX,
							1'b0, ST_OK);
						n_d = n_d + 2'd1;
						bundle_d.slots[n_d] = mk_slot(KIND_JPEG, STREAM_JPEG, b, 1'b0, ST_OK);
						n_d = n_d + 2'd1;
						if (b == MARK_SOS) begin
							sos_d   = 1'b1;
							phase_d = PH_PASS;
						end
					end
				end else if (b == MARK_PREFIX) begin
					held_d = 1'b1;
				end else begin
					bundle_d.slots[n_d] = mk_slot(KIND_JPEG, STREAM_JPEG, b, 1'b0, ST_OK);
					n_d = n_d + 2'd1;
				end
			end
		endcase

		// The first error of a frame is kept; the rest of the frame is dropped.
		if (fail_d) begin
			if (err_q == ST_OK) begin
				err_d = code_d;
			end
			phase_d = PH_DISCARD;
			held_d  = 1'b0;
		end

		// Frame end: flush a held prefix, report status, reset all but the known formats.
		if (fl) begin
			if (held_d) begin
				bundle_d.slots[n_d] = mk_slot(KIND_JPEG, STREAM_JPEG, MARK_PREFIX,
					1'b0, ST_OK);
				n_d = n_d + 2'd1;
			end
			if (err_d != ST_OK) begin
				end_st = err_d;
			end else if (open_d) begin
				end_st = ST_INCOMPLETE;
			end else if (!sos_d) begin
				end_st = ST_NO_SOS;
			end else begin
				end_st = ST_OK;
			end
			bundle_d.slots[n_d] = mk_slot(KIND_END, STREAM_JPEG, 8'h00, 1'b0, end_st);
			n_d = n_d + 2'd1;
			phase_d = PH_SCAN;
			held_d  = 1'b0;
			seg_d   = '0;
			cnt_d   = '0;
			aux_d   = '0;
			open_d  = 1'b0;
			shift_d = '0;
			tail_d  = '0;
			type_d  = '0;
			route_d = STREAM_JPEG;
			sos_d   = 1'b0;
			err_d   = ST_OK;
		end

		bundle_d.count = n_d;
	end

	assign bundle_valid = accept && (n_d != 2'd0);
	assign bundle       = bundle_d;

	// Parser state, advanced on each accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCAN;
			held_q  <= 1'b0;
			seg_q   <= '0;
			cnt_q   <= '0;
			aux_q   <= '0;
			open_q  <= 1'b0;
			shift_q <= '0;
			tail_q  <= '0;
			type_q  <= '0;
			route_q <= STREAM_JPEG;
			sos_q   <= 1'b0;
			err_q   <= ST_OK;
			known_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			seg_q   <= seg_d;
			cnt_q   <= cnt_d;
			aux_q   <= aux_d;
			open_q  <= open_d;
			shift_q <= shift_d;
			tail_q  <= tail_d;
			type_q  <= type_d;
			route_q <= route_d;
			sos_q   <= sos_d;
			err_q   <= err_d;
			known_q <= known_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/app4d_serialiser.sv -----
// Result register of the APP4 demultiplexer: holds the results of one input
// request and hands them out one per request. Depends on app4d_pkg, app4d_out_if.
`timescale 1ns / 1ps
`default_nettype none

module app4d_serialiser
	import app4d_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     bundle_valid,
	input  wire bundle_t  bundle,
	output logic          bundle_ready,
	app4d_out_if.source   result
);

	bundle_t     bundle_q;
	logic        valid_q;
	logic [1:0]  idx_q;
	slot_t       cur;
	logic        is_last;
	logic        is_info;
	logic        take;

	assign cur     = bundle_q.slots[idx_q];
	assign is_last = (idx_q == (bundle_q.count - 2'd1));
	assign is_info = (cur.kind == KIND_INFO);
	assign take    = valid_q && result.ready;

	// A new set of results may enter once the last one held is being taken.
	assign bundle_ready = !valid_q || (take && is_last);

	// Result fields; header values only on a header result.
	assign result.valid          = valid_q;
	assign result.kind           = cur.kind;
	assign result.stream         = cur.stream;
	assign result.out_byte       = cur.data;
	assign result.unit_last      = cur.unit_last;
	assign result.status         = cur.status;
	assign result.run_last       = is_last;
	assign result.width          = is_info ? bundle_q.info.width : 16'd0;
	assign result.height         = is_info ? bundle_q.info.height : 16'd0;
	assign result.frame_period   = is_info ? bundle_q.info.frame_period : 32'd0;
	assign result.delay          = is_info ? bundle_q.info.delay : 16'd0;
	assign result.pts            = is_info ? bundle_q.info.pts : 32'd0;
	assign result.format_changed = is_info && bundle_q.info.format_changed;

	// Occupancy and position within the held results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (bundle_valid) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (take) begin
			if (is_last) begin
				valid_q <= 1'b0;
				idx_q   <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (bundle_valid) begin
			bundle_q <= bundle;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mjpeg_app4_aux_stream_demux_unit.sv -----
// Top level of the MJPEG APP4 auxiliary stream demultiplexer.
// Depends on app4d_pkg, app4d_in_if, app4d_out_if, app4d_parser, app4d_serialiser.
`timescale 1ns / 1ps
`default_nettype none

// Splits MJPEG frame bytes into JPEG bytes and the payload bytes of auxiliary
// H.264, YUY2 and NV12 units carried in APP4 segments, with one header result
// per new unit and one status result at the last byte of each frame. Each
// input byte is decoded in the cycle it is accepted and its results are
// registered; they leave one per cycle from that register while the result
// channel is ready, starting in the following cycle. A byte that gives at
// most one result therefore lets the block keep pace with one byte per cycle
// while results are taken. A byte that gives two or three results (an FF prefix
// released together with the next byte, or a frame end with its status) holds
// the result register; the next byte is taken in the cycle its last result leaves.
// No reset pass is needed; the block accepts bytes right after reset.
module mjpeg_app4_aux_stream_demux_unit
	import app4d_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	app4d_in_if.sink     frame,
	app4d_out_if.source  result
);

	logic     bundle_valid;
	logic     bundle_ready;
	bundle_t  bundle;

	// Marker and segment decoding.
	app4d_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame        (frame),
		.bundle_ready (bundle_ready),
		.bundle_valid (bundle_valid),
		.bundle       (bundle)
	);

	// Result register and output sequencing.
	app4d_serialiser u_serialiser (
		.clk          (clk),
		.arst_n       (arst_n),
		.bundle_valid (bundle_valid),
		.bundle       (bundle),
		.bundle_ready (bundle_ready),
		.result       (result)
	);

endmodule

`default_nettype wire
